@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define VCWH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define VCWH_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/vcwh_pkg.sv @@
`default_nettype none

package vcwh_pkg;

  localparam int FRAC_BITS = 8;

  // Field widths
  localparam int VEL_W = 20;
  localparam int POS_W = 24;
  localparam int RAD_W = 16;
  localparam int CFG_W = 16;

  // Configuration registers
  localparam int NUM_CFG   = 2;
  localparam int CFG_IDX_W = (NUM_CFG > 1) ? $clog2(NUM_CFG) : 1;
  localparam logic [CFG_IDX_W-1:0] CFG_AGENT_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_HORIZON = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     HORIZON_RST      = CFG_W'(256);

  // Shared multiplier: 32x32 partial products into a 128-bit accumulator
  localparam int HALF_W = 32;
  localparam int OP_W   = 2 * HALF_W;
  localparam int ACC_W  = 4 * HALF_W;

  // Magnitude widths of the intermediates
  localparam int PMAG_W = POS_W + 1;
  localparam int VMAG_W = VEL_W + 1;
  localparam int RSUM_W = RAD_W + 1;
  localparam int PV_W   = PMAG_W + VMAG_W;
  localparam int VV_W   = 2 * VMAG_W + 1;
  localparam int C_W    = 2 * PMAG_W + 1;
  localparam int A_W    = VV_W + CFG_W;

  // Product terms, issued in this order
  typedef enum logic [3:0] {
    T_PV0,
    T_PV1,
    T_VV0,
    T_VV1,
    T_C0,
    T_C1,
    T_C2,
    T_A0,
    T_A1,
    T_E0,
    T_E1,
    T_E2
  } term_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic xi;
    logic yi;
  } mac_ctrl_t;

  typedef struct packed {
    logic  idle;
    logic  fin;
    logic  cap_vld;
    term_t cap_term;
    term_t term;
  } seq_stat_t;

endpackage

`default_nettype wire

@@ hdl/vcwh_in_if.sv @@
`default_nettype none

interface vcwh_in_if;
  import vcwh_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] cand_vel_x;
  logic signed [VEL_W-1:0] cand_vel_y;
  logic signed [POS_W-1:0] actor_x;
  logic signed [POS_W-1:0] actor_y;
  logic signed [POS_W-1:0] nb_pos_x;
  logic signed [POS_W-1:0] nb_pos_y;
  logic signed [VEL_W-1:0] nb_vel_x;
  logic signed [VEL_W-1:0] nb_vel_y;
  logic        [RAD_W-1:0] neighbour_radius;
  logic                    last_neighbour;

  modport source (
    output valid, cand_vel_x, cand_vel_y, actor_x, actor_y, nb_pos_x, nb_pos_y,
           nb_vel_x, nb_vel_y, neighbour_radius, last_neighbour,
    input  ready
  );

  modport sink (
    input  valid, cand_vel_x, cand_vel_y, actor_x, actor_y, nb_pos_x, nb_pos_y,
           nb_vel_x, nb_vel_y, neighbour_radius, last_neighbour,
    output ready
  );

endinterface

`default_nettype wire

@@ hdl/vcwh_out_if.sv @@
`default_nettype none

interface vcwh_out_if;

  logic valid;
  logic ready;
  logic forbidden;

  modport source (output valid, forbidden, input ready);
  modport sink (input valid, forbidden, output ready);

endinterface

`default_nettype wire

@@ hdl/velocity_collision_within_horizon_core.sv @@
// Collision test of one candidate velocity against a list of neighbours.
// in_if carries one neighbour per beat: candidate velocity, own position,
// neighbour position, velocity and radius, and last_neighbour on the final
// beat of a list. out_if carries one beat per list, forbidden = 1 when any
// neighbour of that list collides within the time horizon.
// cfg_we/cfg_idx/cfg_data write agent_radius (index 0) and time_horizon
// (index 1); write them only while no neighbour is in flight.
// Each neighbour is issued term by term on the shared 32x32 multiplier
// and its 128-bit accumulator (12 product terms split into partial
// products), then drains that pipeline and returns to idle through its
// finish step. in_if.ready is high only while idle. The verdict is
// registered onto out_if as the finish step of the last beat completes.
// The output register lets the next list start while a verdict waits; a
// verdict that cannot be loaded because the previous one is still untaken
// holds the block in its finish step until out_if.ready.
// Reset clears the pending verdict and the running hit flag, sets
// agent_radius to 0 and time_horizon to 1.0 s.
`default_nettype none
`include "assert_macros.svh"

module velocity_collision_within_horizon_core (
  input  logic                           clk,
  input  logic                           rst_n,
  vcwh_in_if.sink                        in_if,
  vcwh_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [vcwh_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [vcwh_pkg::CFG_W-1:0]     cfg_data
);
  import vcwh_pkg::*;

  localparam logic [OP_W-1:0] SCALE = OP_W'(1) << FRAC_BITS;

  mac_ctrl_t mac_ctrl;
  seq_stat_t stat;

  logic [CFG_W-1:0] agent_radius_r;
  logic [CFG_W-1:0] time_horizon_r;

  logic in_fire;
  logic fin_ok;
  logic fin_go;

  // Relative quantities of the incoming beat
  logic signed [PMAG_W-1:0] px_s;
  logic signed [PMAG_W-1:0] py_s;
  logic signed [VMAG_W-1:0] vx_s;
  logic signed [VMAG_W-1:0] vy_s;

  logic [PMAG_W-1:0] px_mag_r;
  logic [PMAG_W-1:0] py_mag_r;
  logic [VMAG_W-1:0] vx_mag_r;
  logic [VMAG_W-1:0] vy_mag_r;
  logic              pv0_neg_r;
  logic              pv1_neg_r;
  logic [RSUM_W-1:0] rsum_r;
  logic              last_r;

  // Captured sums
  logic              pv_pos_r;
  logic [PV_W-1:0]   pv_mag_r;
  logic              vv_nz_r;
  logic [VV_W-1:0]   vv_r;
  logic              c_neg_r;
  logic              c_pos_r;
  logic [C_W-1:0]    c_mag_r;
  logic              a_le0_r;
  logic [A_W-1:0]    a_mag_r;
  logic              sd_neg_r;

  logic [OP_W-1:0]   x_op;
  logic [OP_W-1:0]   y_op;
  logic              op_neg;
  logic [ACC_W-1:0]  acc;
  logic              acc_nz;
  logic              acc_neg;
  logic [C_W-1:0]    acc_c;
  logic [A_W-1:0]    acc_a;
  logic              hit;

  logic out_valid_r;
  logic forbidden_r;
  logic hit_seen_r;

  assign in_if.ready = stat.idle;
  assign in_fire     = in_if.valid && in_if.ready;

  assign px_s = PMAG_W'(in_if.nb_pos_x) - PMAG_W'(in_if.actor_x);
  assign py_s = PMAG_W'(in_if.nb_pos_y) - PMAG_W'(in_if.actor_y);
  assign vx_s = VMAG_W'(in_if.cand_vel_x) - VMAG_W'(in_if.nb_vel_x);
  assign vy_s = VMAG_W'(in_if.cand_vel_y) - VMAG_W'(in_if.nb_vel_y);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_mag_r  <= px_s[PMAG_W-1] ? $unsigned(-px_s) : $unsigned(px_s);
      py_mag_r  <= py_s[PMAG_W-1] ? $unsigned(-py_s) : $unsigned(py_s);
      vx_mag_r  <= vx_s[VMAG_W-1] ? $unsigned(-vx_s) : $unsigned(vx_s);
      vy_mag_r  <= vy_s[VMAG_W-1] ? $unsigned(-vy_s) : $unsigned(vy_s);
      pv0_neg_r <= px_s[PMAG_W-1] ^ vx_s[VMAG_W-1];
      pv1_neg_r <= py_s[PMAG_W-1] ^ vy_s[VMAG_W-1];
      rsum_r    <= RSUM_W'(agent_radius_r) + RSUM_W'(in_if.neighbour_radius);
      last_r    <= in_if.last_neighbour;
    end
  end

  // Operands per term. The A and E terms work on |PV|; a non-positive PV
  // is rejected at the end anyway.
  always_comb begin
    x_op   = '0;
    y_op   = '0;
    op_neg = 1'b0;
    unique case (stat.term)
      T_PV0: begin
        x_op   = OP_W'(px_mag_r);
        y_op   = OP_W'(vx_mag_r);
        op_neg = pv0_neg_r;
      end
      T_PV1: begin
        x_op   = OP_W'(py_mag_r);
        y_op   = OP_W'(vy_mag_r);
        op_neg = pv1_neg_r;
      end
      T_VV0: begin
        x_op = OP_W'(vx_mag_r);
        y_op = OP_W'(vx_mag_r);
      end
      T_VV1: begin
        x_op = OP_W'(vy_mag_r);
        y_op = OP_W'(vy_mag_r);
      end
      T_C0: begin
        x_op = OP_W'(px_mag_r);
        y_op = OP_W'(px_mag_r);
      end
      T_C1: begin
        x_op = OP_W'(py_mag_r);
        y_op = OP_W'(py_mag_r);
      end
      T_C2: begin
        x_op   = OP_W'(rsum_r);
        y_op   = OP_W'(rsum_r);
        op_neg = 1'b1;
      end
      T_A0: begin
        x_op = OP_W'(pv_mag_r);
        y_op = SCALE;
      end
      T_A1: begin
        x_op   = OP_W'(vv_r);
        y_op   = OP_W'(time_horizon_r);
        op_neg = 1'b1;
      end
      T_E0: begin
        // s^2*VV*C, sign from C
        x_op   = OP_W'(vv_r) << (2 * FRAC_BITS);
        y_op   = OP_W'(c_mag_r);
        op_neg = c_neg_r;
      end
      T_E1: begin
        x_op   = OP_W'(pv_mag_r) << FRAC_BITS;
        y_op   = OP_W'(pv_mag_r) << FRAC_BITS;
        op_neg = 1'b1;
      end
      T_E2: begin
        x_op = OP_W'(a_mag_r);
        y_op = OP_W'(a_mag_r);
      end
      default: begin
        x_op   = '0;
        y_op   = '0;
        op_neg = 1'b0;
      end
    endcase
  end

  vcwh_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_fire),
    .fin_ok (fin_ok),
    .ctrl   (mac_ctrl),
    .stat   (stat)
  );

  vcwh_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .neg   (op_neg),
    .x_op  (x_op),
    .y_op  (y_op),
    .acc   (acc)
  );

  assign acc_nz  = |acc;
  assign acc_neg = acc[ACC_W-1];
  assign acc_c   = acc[C_W-1:0];
  assign acc_a   = acc[A_W-1:0];

  // Latch each finished sum as it leaves the accumulator
  always_ff @(posedge clk) begin
    if (stat.cap_vld) begin
      unique case (stat.cap_term)
        T_PV1: begin
          pv_pos_r <= !acc_neg && acc_nz;
          pv_mag_r <= acc[PV_W-1:0];
        end
        T_VV1: begin
          vv_r    <= acc[VV_W-1:0];
          vv_nz_r <= |acc[VV_W-1:0];
        end
        T_C2: begin
          c_neg_r <= acc_neg;
          c_pos_r <= !acc_neg && acc_nz;
          c_mag_r <= acc_neg ? -acc_c : acc_c;
        end
        T_A1: begin
          a_le0_r <= acc_neg || !acc_nz;
          a_mag_r <= acc_neg ? -acc_a : acc_a;
        end
        T_E1: begin
          // acc holds -s^2*d here
          sd_neg_r <= !acc_neg && acc_nz;
        end
        default: begin
        end
      endcase
    end
  end

  // At finish acc holds A^2 - s^2*d
  assign hit = pv_pos_r && vv_nz_r && !sd_neg_r &&
               (c_pos_r ? (a_le0_r || acc_neg || !acc_nz) : (a_le0_r && !acc_neg));

  assign fin_ok = !last_r || !out_valid_r || out_if.ready;
  assign fin_go = stat.fin && fin_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      hit_seen_r     <= 1'b0;
      agent_radius_r <= '0;
      time_horizon_r <= HORIZON_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_AGENT_RADIUS: agent_radius_r <= cfg_data;
          CFG_TIME_HORIZON: time_horizon_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (fin_go) begin
        if (last_r) begin
          out_valid_r <= 1'b1;
          hit_seen_r  <= 1'b0;
        end else begin
          hit_seen_r <= hit_seen_r || hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && last_r) begin
      forbidden_r <= hit_seen_r || hit;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.forbidden = forbidden_r;

  `VCWH_ASSERT(a_result_from_fin, $rose(out_valid_r) |-> $past(fin_go && last_r), "verdict raised outside a list end")
  `VCWH_ASSERT(a_list_clears_flag, (fin_go && last_r) |=> !hit_seen_r, "hit flag survived end of list")
  `VCWH_ASSERT(a_busy_after_beat, in_fire |=> !stat.idle && (stat.term == T_PV0), "sequencer did not start on beat")
  `VCWH_NEVER(a_fin_not_from_idle, stat.fin && $past(stat.idle), "finish step entered straight from idle")

endmodule

`default_nettype wire

@@ hdl/vcwh_mac.sv @@
`default_nettype none

module vcwh_mac (
  input  logic                      clk,
  input  logic                      rst_n,
  input  vcwh_pkg::mac_ctrl_t       ctrl,
  input  logic                      neg,
  input  logic [vcwh_pkg::OP_W-1:0] x_op,
  input  logic [vcwh_pkg::OP_W-1:0] y_op,
  output logic [vcwh_pkg::ACC_W-1:0] acc
);
  import vcwh_pkg::*;

  logic [HALF_W-1:0] x_half;
  logic [HALF_W-1:0] y_half;
  logic [OP_W-1:0]   prod_r;
  logic              en_r;
  logic              clr_r;
  logic              neg_r;
  logic [1:0]        sh_r;
  logic [ACC_W-1:0]  pp_ext;
  logic [ACC_W-1:0]  base;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;

  assign x_half = ctrl.xi ? x_op[OP_W-1:HALF_W] : x_op[HALF_W-1:0];
  assign y_half = ctrl.yi ? y_op[OP_W-1:HALF_W] : y_op[HALF_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= ctrl.en;
    end
  end

  // Product stage, then accumulate stage
  always_ff @(posedge clk) begin
    prod_r <= OP_W'(x_half) * OP_W'(y_half);
    clr_r  <= ctrl.clr;
    neg_r  <= neg;
    sh_r   <= {ctrl.xi & ctrl.yi, ctrl.xi ^ ctrl.yi};
    if (en_r) begin
      acc_r <= acc_nxt;
    end
  end

  always_comb begin
    unique case (sh_r)
      2'd0:    pp_ext = ACC_W'(prod_r);
      2'd1:    pp_ext = ACC_W'(prod_r) << HALF_W;
      2'd2:    pp_ext = ACC_W'(prod_r) << (2 * HALF_W);
      default: pp_ext = '0;
    endcase
    base    = clr_r ? '0 : acc_r;
    acc_nxt = neg_r ? (base - pp_ext) : (base + pp_ext);
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

@@ hdl/vcwh_seq.sv @@
`default_nettype none
`include "assert_macros.svh"

module vcwh_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                fin_ok,
  output vcwh_pkg::mac_ctrl_t ctrl,
  output vcwh_pkg::seq_stat_t stat
);
  import vcwh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FIN
  } state_t;

  state_t state_r;
  term_t  term_r;
  logic   xi_r;
  logic   yi_r;
  logic   cap1_vld_r;
  term_t  cap1_term_r;
  logic   cap2_vld_r;
  term_t  cap2_term_r;
  logic   xw;
  logic   yw;
  logic   pp_last;

  // Upper operand half needed
  function automatic logic x_wide(input term_t t);
    logic w;
    case (t)
      T_A0, T_A1, T_E0, T_E1, T_E2: w = 1'b1;
      default:                      w = 1'b0;
    endcase
    return w;
  endfunction

  function automatic logic y_wide(input term_t t);
    logic w;
    case (t)
      T_E0, T_E1, T_E2: w = 1'b1;
      default:          w = 1'b0;
    endcase
    return w;
  endfunction

  // Terms that open a new sum
  function automatic logic clr_first(input term_t t);
    logic c;
    case (t)
      T_PV0, T_VV0, T_C0, T_A0, T_E0: c = 1'b1;
      default:                        c = 1'b0;
    endcase
    return c;
  endfunction

  assign xw      = x_wide(term_r);
  assign yw      = y_wide(term_r);
  assign pp_last = (xi_r == xw) && (yi_r == yw);

  assign ctrl.en  = (state_r == S_RUN);
  assign ctrl.clr = (state_r == S_RUN) && !xi_r && !yi_r && clr_first(term_r);
  assign ctrl.xi  = xi_r;
  assign ctrl.yi  = yi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      term_r     <= T_PV0;
      xi_r       <= 1'b0;
      yi_r       <= 1'b0;
      cap1_vld_r <= 1'b0;
      cap2_vld_r <= 1'b0;
    end else begin
      // Track each finished term down the two multiplier stages
      cap1_vld_r  <= ctrl.en && pp_last;
      cap1_term_r <= term_r;
      cap2_vld_r  <= cap1_vld_r;
      cap2_term_r <= cap1_term_r;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RUN;
            term_r  <= T_PV0;
            xi_r    <= 1'b0;
            yi_r    <= 1'b0;
          end
        end
        S_RUN: begin
          if (pp_last) begin
            xi_r <= 1'b0;
            yi_r <= 1'b0;
            if (term_r == T_E2) begin
              state_r <= S_DRAIN;
            end else begin
              term_r <= term_t'(term_r + 4'd1);
            end
          end else if (yi_r != yw) begin
            yi_r <= 1'b1;
          end else begin
            yi_r <= 1'b0;
            xi_r <= 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle     = (state_r == S_IDLE);
  assign stat.fin      = (state_r == S_FIN);
  assign stat.cap_vld  = cap2_vld_r;
  assign stat.cap_term = cap2_term_r;
  assign stat.term     = term_r;

  `VCWH_ASSERT(a_fin_meets_last_sum, (state_r == S_DRAIN) |=> (state_r == S_FIN) && cap2_vld_r && (cap2_term_r == T_E2), "final sum not aligned with finish")

endmodule

`default_nettype wire
